FILE: rtl/ght_pkg.sv
// shared types and codes for the generational handle table
package ght_pkg;

	localparam int OBJ_W    = 32;
	localparam int CAPS_W   = 16;
	localparam int GEN_W    = 16;
	localparam int HANDLE_W = 64;
	localparam int HIDX_W   = 32;
	localparam int STATUS_W = 3;

	// request operations
	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RESOLVE = 2'd1,
		OP_DUP     = 2'd2,
		OP_CLOSE   = 2'd3
	} opcode_t;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NULL_OBJ  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_HCAPS     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd4;
	localparam logic [STATUS_W-1:0] ST_STALE     = 3'd5;
	localparam logic [STATUS_W-1:0] ST_ECAPS     = 3'd6;

	// generation every slot starts with
	localparam logic [GEN_W-1:0] GEN_INIT = 16'd1;

	// one slot of the table
	typedef struct packed {
		logic [OBJ_W-1:0]  obj;
		logic [CAPS_W-1:0] caps;
		logic [GEN_W-1:0]  gen;
	} slot_t;

	// next generation, skipping zero on wrap
	function automatic logic [GEN_W-1:0] next_gen(input logic [GEN_W-1:0] gen);
		logic [GEN_W-1:0] ng;
		ng = gen + GEN_W'(1);
		if (ng == '0) begin
			ng = GEN_INIT;
		end
		return ng;
	endfunction

endpackage

FILE: rtl/ght_ram.sv
// generic simple dual-port ram with registered read
module ght_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/ght_stack.sv
// lifo of free slot indices, each kept with the slot's current generation
module ght_stack
	import ght_pkg::*;
#(
	parameter int SLOTS = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     init_en,
	input  logic [$clog2(SLOTS)-1:0] init_addr,
	input  logic                     rd_en,
	input  logic                     pop,
	input  logic                     push,
	input  logic [$clog2(SLOTS)-1:0] push_idx,
	input  logic [GEN_W-1:0]         push_gen,
	output logic [$clog2(SLOTS)-1:0] top_idx,
	output logic [GEN_W-1:0]         top_gen,
	output logic                     empty
);

	localparam int IW = $clog2(SLOTS);
	localparam int EW = IW + GEN_W;
	localparam logic [IW-1:0] MAX_DEPTH = IW'(SLOTS - 1);

	logic [IW-1:0] depth_q;
	logic          full;
	logic          we;
	logic [IW-1:0] waddr;
	logic [EW-1:0] wdata;
	logic [EW-1:0] rdata;

	assign empty = (depth_q == '0);
	assign full  = (depth_q == MAX_DEPTH);

	// init sweep puts slot 1 on top, otherwise push at the current depth
	always_comb begin
		we    = init_en | (push & ~full);
		waddr = init_en ? init_addr : depth_q;
		wdata = init_en ? {MAX_DEPTH - init_addr, GEN_INIT} : {push_idx, push_gen};
	end

	ght_ram #(
		.WIDTH(EW),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (rd_en),
		.raddr(depth_q - IW'(1)),
		.rdata(rdata)
	);

	assign top_idx = rdata[EW-1:GEN_W];
	assign top_gen = rdata[GEN_W-1:0];

	// stack depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= MAX_DEPTH;
		end else if (pop) begin
			depth_q <= depth_q - IW'(1);
		end else if (push && !full) begin
			depth_q <= depth_q + IW'(1);
		end
	end

endmodule

FILE: rtl/generational_handle_table.sv
// Generational handle table: slot memory plus a free-index stack.
// A request is taken when start is high and busy low; its result strobes on done
// from the result registers, loaded while phase_q is high; busy stays high until
// the slot read-modify-write is done. After reset a clearing pass over every slot
// initializes both memories while busy is high. Results cannot be stalled.
module generational_handle_table
	import ght_pkg::*;
#(
	parameter int SLOTS = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          opcode,
	input  logic [HANDLE_W-1:0] handle_in,
	input  logic [OBJ_W-1:0]    object_id,
	input  logic [CAPS_W-1:0]   cap_bits,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [HANDLE_W-1:0] handle_out,
	output logic [OBJ_W-1:0]    object_out,
	output logic                take_ref,
	output logic                drop_ref
);

	localparam int IW = $clog2(SLOTS);
	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

	logic clearing_q;
	logic [IW-1:0] clr_q;
	logic phase_q;
	logic accept;

	// request registers
	opcode_t            op_s1;
	logic [IW-1:0]      hidx_s1;
	logic               idx_ok_s1;
	logic [GEN_W-1:0]   hgen_s1;
	logic [CAPS_W-1:0]  hcaps_s1;
	logic [OBJ_W-1:0]   obj_s1;
	logic [CAPS_W-1:0]  caps_s1;

	// memory interfaces
	slot_t          slot_rd;
	slot_t          slot_wdata;
	logic [IW-1:0]  slot_waddr;
	logic           slot_we;
	logic [IW-1:0]  top_idx;
	logic [GEN_W-1:0] top_gen;
	logic           stk_empty;
	logic           pop;
	logic           push;

	// result logic
	logic [STATUS_W-1:0] live_st;
	logic [STATUS_W-1:0] st_d;
	logic [HANDLE_W-1:0] handle_d;
	logic [OBJ_W-1:0]    obj_d;
	logic                take_d;
	logic                drop_d;
	logic                op_we;
	logic [IW-1:0]       op_waddr;
	slot_t               op_wdata;

	logic [HIDX_W-1:0] in_idx;

	assign in_idx = handle_in[HIDX_W-1:0];
	assign busy   = clearing_q | phase_q;
	assign accept = start & ~busy;

	// clearing pass and request sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
			phase_q    <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_q <= clr_q + IW'(1);
				if (clr_q == LAST) begin
					clearing_q <= 1'b0;
				end
			end
			phase_q <= accept;
		end
	end

	// capture request fields
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= opcode_t'(opcode);
			hidx_s1   <= in_idx[IW-1:0];
			idx_ok_s1 <= (in_idx != '0) && ({1'b0, in_idx} < (HIDX_W + 1)'(SLOTS));
			hgen_s1   <= handle_in[HIDX_W +: GEN_W];
			hcaps_s1  <= handle_in[HIDX_W + GEN_W +: CAPS_W];
			obj_s1    <= object_id;
			caps_s1   <= cap_bits;
		end
	end

	ght_ram #(
		.WIDTH($bits(slot_t)),
		.DEPTH(SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (slot_we),
		.waddr(slot_waddr),
		.wdata(slot_wdata),
		.re   (accept),
		.raddr(in_idx[IW-1:0]),
		.rdata(slot_rd)
	);

	ght_stack #(
		.SLOTS(SLOTS)
	) u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.init_en  (clearing_q),
		.init_addr(clr_q),
		.rd_en    (accept),
		.pop      (pop),
		.push     (push),
		.push_idx (hidx_s1),
		.push_gen (op_wdata.gen),
		.top_idx  (top_idx),
		.top_gen  (top_gen),
		.empty    (stk_empty)
	);

	// index and staleness check
	always_comb begin
		if (!idx_ok_s1) begin
			live_st = ST_BAD_INDEX;
		end else if (slot_rd.gen != hgen_s1 || slot_rd.obj == '0) begin
			live_st = ST_STALE;
		end else begin
			live_st = ST_OK;
		end
	end

	// evaluate the request against the slot read
	always_comb begin
		st_d     = ST_OK;
		handle_d = '0;
		obj_d    = '0;
		take_d   = 1'b0;
		drop_d   = 1'b0;
		op_we    = 1'b0;
		op_waddr = top_idx;
		op_wdata = '{obj: '0, caps: '0, gen: next_gen(slot_rd.gen)};
		pop      = 1'b0;
		push     = 1'b0;
		case (op_s1)
			OP_ALLOC: begin
				if (obj_s1 == '0) begin
					st_d = ST_NULL_OBJ;
				end else if (stk_empty) begin
					st_d = ST_FULL;
				end else begin
					op_we    = 1'b1;
					op_wdata = '{obj: obj_s1, caps: caps_s1, gen: top_gen};
					pop      = 1'b1;
					handle_d = {caps_s1, top_gen, HIDX_W'(top_idx)};
					obj_d    = obj_s1;
					take_d   = 1'b1;
				end
			end
			OP_RESOLVE: begin
				if ((hcaps_s1 & caps_s1) != caps_s1) begin
					st_d = ST_HCAPS;
				end else if (live_st != ST_OK) begin
					st_d = live_st;
				end else if ((slot_rd.caps & caps_s1) != caps_s1) begin
					st_d = ST_ECAPS;
				end else begin
					obj_d  = slot_rd.obj;
					take_d = 1'b1;
				end
			end
			OP_DUP: begin
				if (live_st != ST_OK) begin
					st_d = live_st;
				end else if ((slot_rd.caps & caps_s1) != caps_s1) begin
					st_d = ST_ECAPS;
				end else if (stk_empty) begin
					st_d = ST_FULL;
				end else begin
					op_we    = 1'b1;
					op_wdata = '{obj: slot_rd.obj, caps: caps_s1, gen: top_gen};
					pop      = 1'b1;
					handle_d = {caps_s1, top_gen, HIDX_W'(top_idx)};
					obj_d    = slot_rd.obj;
					take_d   = 1'b1;
				end
			end
			OP_CLOSE: begin
				if (live_st != ST_OK) begin
					st_d = live_st;
				end else begin
					op_we    = 1'b1;
					op_waddr = hidx_s1;
					push     = 1'b1;
					obj_d    = slot_rd.obj;
					drop_d   = 1'b1;
				end
			end
			default: begin
				st_d = ST_OK;
			end
		endcase
		// writes and stack moves only in the evaluate cycle
		if (!phase_q) begin
			op_we = 1'b0;
			pop   = 1'b0;
			push  = 1'b0;
		end
	end

	// slot write port: clearing pass or write-back
	always_comb begin
		if (clearing_q) begin
			slot_we    = 1'b1;
			slot_waddr = clr_q;
			slot_wdata = '{obj: '0, caps: '0, gen: GEN_INIT};
		end else begin
			slot_we    = op_we;
			slot_waddr = op_waddr;
			slot_wdata = op_wdata;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= phase_q;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (phase_q) begin
			status     <= st_d;
			handle_out <= handle_d;
			object_out <= obj_d;
			take_ref   <= take_d;
			drop_ref   <= drop_d;
		end
	end

endmodule

FILE: tb/sv/handle_table_checker.sv
`timescale 1ns / 100ps
// scoreboard for the handle table: tracks slot state and checks every result
module handle_table_checker
	import ght_pkg::*;
#(
	parameter int SLOTS = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic [1:0]          opcode,
	input  logic [HANDLE_W-1:0] handle_in,
	input  logic [OBJ_W-1:0]    object_id,
	input  logic [CAPS_W-1:0]   cap_bits,
	input  logic                done,
	input  logic [STATUS_W-1:0] status,
	input  logic [HANDLE_W-1:0] handle_out,
	input  logic [OBJ_W-1:0]    object_out,
	input  logic                take_ref,
	input  logic                drop_ref,
	output int                  fail_count,
	output int                  outstanding
);

	// one result as the table should report it
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [HANDLE_W-1:0] handle;
		logic [OBJ_W-1:0]    obj;
		logic                take;
		logic                drop;
	} table_result_t;

	// shadow copy of the slot table and free stack
	logic [OBJ_W-1:0]  obj_of   [SLOTS];
	logic [CAPS_W-1:0] caps_of  [SLOTS];
	logic [GEN_W-1:0]  gen_of   [SLOTS];
	logic [HIDX_W-1:0] free_idx [SLOTS];
	int                free_count = 0;

	table_result_t expected_results[$];
	int            errors = 0;
	int            queued = 0;

	assign fail_count  = errors;
	assign outstanding = queued;

	// index range, then generation match and occupancy
	function automatic logic [STATUS_W-1:0] liveness(input logic [HIDX_W-1:0] idx,
			input logic [GEN_W-1:0] gen);
		if (idx == '0 || idx >= SLOTS) begin
			return ST_BAD_INDEX;
		end
		if (gen_of[idx] != gen || obj_of[idx] == '0) begin
			return ST_STALE;
		end
		return ST_OK;
	endfunction

	// pop a free slot and register the object in it
	function automatic table_result_t take_slot(input logic [OBJ_W-1:0] obj,
			input logic [CAPS_W-1:0] caps);
		table_result_t r;
		logic [HIDX_W-1:0] idx;
		r = '0;
		if (obj == '0) begin
			r.status = ST_NULL_OBJ;
			return r;
		end
		if (free_count == 0) begin
			r.status = ST_FULL;
			return r;
		end
		free_count--;
		idx = free_idx[free_count];
		obj_of[idx]  = obj;
		caps_of[idx] = caps;
		r.status = ST_OK;
		r.handle = {caps, gen_of[idx], idx};
		r.obj    = obj;
		r.take   = 1'b1;
		return r;
	endfunction

	// apply one request to the shadow table and return its result
	function automatic table_result_t predict_request(input opcode_t op,
			input logic [HANDLE_W-1:0] h, input logic [OBJ_W-1:0] obj,
			input logic [CAPS_W-1:0] caps);
		table_result_t     r;
		logic [HIDX_W-1:0] hidx;
		logic [GEN_W-1:0]  hgen;
		logic [CAPS_W-1:0] hcaps;
		logic [GEN_W-1:0]  ng;
		logic [STATUS_W-1:0] st;
		hidx  = h[31:0];
		hgen  = h[47:32];
		hcaps = h[63:48];
		r = '0;
		case (op)
			OP_ALLOC: begin
				r = take_slot(obj, caps);
			end
			OP_RESOLVE: begin
				// handle caps are checked before anything else
				if ((hcaps & caps) != caps) begin
					r.status = ST_HCAPS;
				end else begin
					st = liveness(hidx, hgen);
					if (st != ST_OK) begin
						r.status = st;
					end else if ((caps_of[hidx] & caps) != caps) begin
						r.status = ST_ECAPS;
					end else begin
						r.obj  = obj_of[hidx];
						r.take = 1'b1;
					end
				end
			end
			OP_DUP: begin
				// the handle's own caps field plays no part here
				st = liveness(hidx, hgen);
				if (st != ST_OK) begin
					r.status = st;
				end else if ((caps_of[hidx] & caps) != caps) begin
					r.status = ST_ECAPS;
				end else begin
					r = take_slot(obj_of[hidx], caps);
				end
			end
			default: begin
				st = liveness(hidx, hgen);
				if (st != ST_OK) begin
					r.status = st;
				end else begin
					r.obj  = obj_of[hidx];
					r.drop = 1'b1;
					obj_of[hidx]  = '0;
					caps_of[hidx] = '0;
					// generation skips zero on wrap
					ng = gen_of[hidx] + 16'd1;
					if (ng == '0) begin
						ng = GEN_INIT;
					end
					gen_of[hidx] = ng;
					if (free_count < SLOTS - 1) begin
						free_idx[free_count] = hidx;
						free_count++;
					end
				end
			end
		endcase
		return r;
	endfunction

	// compare results, then record newly accepted requests
	always @(posedge clk or negedge arst_n) begin
		table_result_t want;
		if (!arst_n) begin
			for (int k = 0; k < SLOTS; k++) begin
				obj_of[k]   = '0;
				caps_of[k]  = '0;
				gen_of[k]   = GEN_INIT;
				free_idx[k] = '0;
			end
			// slot 1 on top of the stack
			for (int k = 0; k < SLOTS - 1; k++) begin
				free_idx[k] = HIDX_W'(SLOTS - 1 - k);
			end
			free_count = SLOTS - 1;
			expected_results.delete();
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("unexpected result: status %0d handle %h obj %h take %b drop %b",
							status, handle_out, object_out, take_ref, drop_ref);
					end
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status || handle_out !== want.handle ||
							object_out !== want.obj || take_ref !== want.take ||
							drop_ref !== want.drop) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch at %0t: status %0d/%0d handle %h/%h",
								$realtime, want.status, status, want.handle, handle_out);
							$display("  obj %h/%h take %b/%b drop %b/%b (expected/actual)",
								want.obj, object_out, want.take, take_ref, want.drop, drop_ref);
						end
					end
				end
			end
			if (start && !busy) begin
				expected_results.push_back(predict_request(opcode_t'(opcode), handle_in,
					object_id, cap_bits));
			end
		end
		queued = expected_results.size();
	end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// top of the handle table testbench: request stimulus and final verdict
module testbench;
	import ght_pkg::*;

	localparam int SLOTS       = 256;
	localparam int RANDOM_REQS = 1800;
	localparam int IDLE_END    = 1500;

	// request mix of the random part
	typedef enum logic [1:0] {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN
	} mix_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                start      = 1'b0;
	opcode_t             opcode     = OP_ALLOC;
	logic [HANDLE_W-1:0] handle_in  = '0;
	logic [OBJ_W-1:0]    object_id  = '0;
	logic [CAPS_W-1:0]   cap_bits   = '0;
	logic                busy;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_W-1:0] handle_out;
	logic [OBJ_W-1:0]    object_out;
	logic                take_ref;
	logic                drop_ref;
	int                  fail_count;
	int                  outstanding;

	// handles seen so far: believed live, and closed ones for stale use
	logic [HANDLE_W-1:0] live_handles[$];
	logic [HANDLE_W-1:0] closed_handles[$];
	logic [HANDLE_W-1:0] last_handle = '0;
	bit                  learning    = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	generational_handle_table #(
		.SLOTS(SLOTS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.opcode    (opcode),
		.handle_in (handle_in),
		.object_id (object_id),
		.cap_bits  (cap_bits),
		.done      (done),
		.status    (status),
		.handle_out(handle_out),
		.object_out(object_out),
		.take_ref  (take_ref),
		.drop_ref  (drop_ref)
	);

	handle_table_checker #(
		.SLOTS(SLOTS)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.handle_in  (handle_in),
		.object_id  (object_id),
		.cap_bits   (cap_bits),
		.done       (done),
		.status     (status),
		.handle_out (handle_out),
		.object_out (object_out),
		.take_ref   (take_ref),
		.drop_ref   (drop_ref),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	// collect handles handed out by the table
	always @(posedge clk) begin
		if (done) begin
			last_handle <= handle_out;
			if (learning && status == ST_OK && handle_out != '0) begin
				live_handles.push_back(handle_out);
			end
		end
	end

	// present a request and hold it until accepted
	task automatic send(input opcode_t op, input logic [HANDLE_W-1:0] h,
			input logic [OBJ_W-1:0] obj, input logic [CAPS_W-1:0] caps);
		start     <= 1'b1;
		opcode    <= op;
		handle_in <= h;
		object_id <= obj;
		cap_bits  <= caps;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
	endtask

	// sender gap with junk on the request fields
	task automatic rest(input int cycles);
		start     <= 1'b0;
		handle_in <= {$urandom, $urandom};
		object_id <= $urandom;
		repeat (cycles) @(posedge clk);
	endtask

	// hold off until every result has come back
	task automatic settle();
		start <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) begin
			@(negedge clk);
		end
		@(posedge clk);
	endtask

	task automatic send_sync(input opcode_t op, input logic [HANDLE_W-1:0] h,
			input logic [OBJ_W-1:0] obj, input logic [CAPS_W-1:0] caps);
		send(op, h, obj, caps);
		settle();
	endtask

	// mostly live handles, some closed, corrupted or random ones
	function automatic logic [HANDLE_W-1:0] pick_handle(input bit closing);
		logic [HANDLE_W-1:0] h;
		int unsigned         pos;
		int unsigned         r;
		r = $urandom_range(99);
		if (live_handles.size() == 0 || r >= 90) begin
			h = {$urandom, $urandom};
		end else if (r >= 80 && closed_handles.size() != 0) begin
			h = closed_handles[$urandom_range(closed_handles.size() - 1)];
		end else begin
			pos = $urandom_range(live_handles.size() - 1);
			h = live_handles[pos];
			if (r >= 70) begin
				case ($urandom_range(4))
					0: h[32 + $urandom_range(15)] = ~h[32 + $urandom_range(15)];
					1: h[31:0] = '0;
					2: h[31:0] = $urandom_range(32'hFFFF_FFFF, SLOTS);
					3: h[$urandom_range(31)] = ~h[$urandom_range(31)];
					default: h[63:48] = 16'hFFFF;
				endcase
			end else if (closing) begin
				live_handles.delete(pos);
				closed_handles.push_back(h);
				if (closed_handles.size() > 64) begin
					void'(closed_handles.pop_front());
				end
			end
		end
		return h;
	endfunction

	initial begin
		logic [HANDLE_W-1:0] ha, hb, hc, hd, he, h;
		logic [CAPS_W-1:0]   caps;
		logic [OBJ_W-1:0]    obj;
		mix_t                mix;
		int unsigned         r, alloc_lim, dup_lim, resolve_lim;
		bit                  quiet;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: null object, field extremes, every check and its order
		send_sync(OP_ALLOC, '1, '0, 16'hFFFF);
		send_sync(OP_ALLOC, '0, 32'hFFFF_FFFF, 16'hFFFF);
		ha = last_handle;
		send_sync(OP_ALLOC, '1, 32'd1, 16'h0000);
		hb = last_handle;
		send_sync(OP_RESOLVE, ha, '0, 16'hFFFF);
		send_sync(OP_RESOLVE, hb, '1, 16'h0001);
		send_sync(OP_RESOLVE, hb, '1, 16'h0000);
		send_sync(OP_RESOLVE, {ha[63:32], 32'd0}, '0, 16'h0000);
		send_sync(OP_RESOLVE, {ha[63:32], 32'(SLOTS)}, '0, 16'h0000);
		send_sync(OP_RESOLVE, {ha[63:32], 32'hFFFF_FFFF}, '0, 16'h0000);
		// never allocated slot with a matching generation
		send_sync(OP_RESOLVE, {16'hFFFF, GEN_INIT, 32'(SLOTS - 1)}, '0, 16'h0000);
		send_sync(OP_RESOLVE, {ha[63:48], ha[47:32] + 16'd1, ha[31:0]}, '0, 16'h0000);
		// forged handle caps pass, entry caps do not
		send_sync(OP_RESOLVE, {16'hFFFF, hb[47:0]}, '0, 16'h8000);
		send_sync(OP_DUP, ha, '0, 16'h00F0);
		hc = last_handle;
		send_sync(OP_DUP, hc, '0, 16'h0F00);
		send_sync(OP_DUP, {ha[63:32], 32'd0}, '0, 16'h0000);
		send_sync(OP_DUP, {hc[63:48], ~hc[47:32], hc[31:0]}, '0, 16'h0000);
		// dup ignores the caps field of its handle
		send_sync(OP_DUP, {16'h0000, ha[47:0]}, '0, 16'h0003);
		hd = last_handle;
		send_sync(OP_CLOSE, ha, '1, 16'hFFFF);
		send_sync(OP_CLOSE, ha, '0, 16'h0000);
		send_sync(OP_RESOLVE, ha, '0, 16'h0000);
		send_sync(OP_RESOLVE, hc, '0, 16'h00F0);
		send_sync(OP_ALLOC, '0, $urandom | 32'h1, 16'($urandom));
		he = last_handle;
		live_handles = '{hb, hc, hd, he};
		closed_handles = '{ha};
		learning = 1'b1;

		// random: fill and drain phases, then an even mix
		quiet = 1'b0;
		for (int n = 0; n < RANDOM_REQS; n++) begin
			if (n >= 1600) begin
				mix = MIX_EVEN;
			end else if (((n / 400) % 2) == 0) begin
				mix = MIX_FILL;
			end else begin
				mix = MIX_DRAIN;
			end
			case (mix)
				MIX_FILL: begin
					alloc_lim = 60; dup_lim = 75; resolve_lim = 90;
				end
				MIX_DRAIN: begin
					alloc_lim = 10; dup_lim = 20; resolve_lim = 45;
				end
				default: begin
					alloc_lim = 30; dup_lim = 45; resolve_lim = 75;
				end
			endcase
			if (n % 50 == 0) begin
				quiet = ($urandom_range(2) == 0);
			end
			if (!quiet && n < IDLE_END && $urandom_range(2) == 0) begin
				rest($urandom_range(9, 1));
			end
			// once mid-run, let the table empty its pipeline
			if (n == 900) begin
				settle();
			end
			r = $urandom_range(99);
			if (r < alloc_lim) begin
				r = $urandom_range(99);
				obj = (r < 3) ? '0 : (r < 6) ? '1 : $urandom;
				send(OP_ALLOC, {$urandom, $urandom}, obj, 16'($urandom));
			end else if (r < dup_lim) begin
				h = pick_handle(1'b0);
				caps = ($urandom_range(9) < 7) ? (h[63:48] & 16'($urandom)) :
					16'($urandom);
				send(OP_DUP, h, $urandom, caps);
			end else if (r < resolve_lim) begin
				h = pick_handle(1'b0);
				r = $urandom_range(9);
				caps = (r < 6) ? (h[63:48] & 16'($urandom)) : (r < 8) ? 16'($urandom) : '0;
				send(OP_RESOLVE, h, $urandom, caps);
			end else begin
				send(OP_CLOSE, pick_handle(1'b1), $urandom, 16'($urandom));
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
